@@ rtl/core/tor_pkg.sv @@
// shared types, byte codes and the terminal-type reply table for the telnet option responder
// no dependencies
package tor_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;

  localparam int unsigned TTYPE_LEN = 10;
  localparam int unsigned REPLY_LEN = 3;
  localparam int unsigned IDX_W     = $clog2(TTYPE_LEN);

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_IAC    = 4'b0010,
    PH_CMD    = 4'b0100,
    PH_SUB    = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    BURST_NONE  = 2'd0,
    BURST_DATA  = 2'd1,
    BURST_REPLY = 2'd2,
    BURST_TTYPE = 2'd3
  } burst_kind_t;

  typedef struct packed {
    burst_kind_t kind;
    logic [7:0]  cmd;
    logic [7:0]  opt;
  } burst_t;

  function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      4'd0:    b = B_IAC;
      4'd1:    b = B_SB;
      4'd2:    b = OPT_TTYPE;
      4'd3:    b = 8'd0;
      4'd4:    b = 8'd65;
      4'd5:    b = 8'd78;
      4'd6:    b = 8'd83;
      4'd7:    b = 8'd73;
      4'd8:    b = B_IAC;
      4'd9:    b = B_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/telnet_option_responder.sv @@
// Telnet option responder, top level: sorts received bytes into terminal data and option
// replies to the server. A byte is taken every cycle while results flow freely. A byte that
// causes a reply holds the input until every byte of the reply (3 for an option answer, 10
// for the terminal-type subnegotiation answer) is taken. The single result register holds the
// burst, and the input stalls until the last byte of the burst is taken, so the next byte can
// enter in that same cycle. Bytes that cause no result (IAC, command, skipped subnegotiation
// bytes) are taken as soon as the result register is free. Out_ready low stalls the result
// register, and with it the input.
// depends on tor_pkg, tor_parser, tor_emitter
module telnet_option_responder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       to_server,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import tor_pkg::*;

  logic   accept;
  logic   free;
  logic   load;
  burst_t burst;

  assign in_ready = free;
  assign accept   = in_valid && in_ready;
  assign load     = accept && (burst.kind != BURST_NONE);

  tor_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .burst   (burst)
  );

  tor_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .burst       (burst),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .to_server   (to_server),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

@@ rtl/core/tor_parser.sv @@
// command parser: phase and held command registers, decodes each byte into a data, reply or terminal-type burst or none
// depends on tor_pkg
module tor_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  output tor_pkg::burst_t burst
);
  import tor_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_command;
  logic [7:0] held_command_next;

  always_comb begin
    phase_next        = PH_NORMAL;
    held_command_next = held_command;
    burst.kind        = BURST_NONE;
    burst.cmd         = B_WONT;
    burst.opt         = in_byte;
    unique case (phase)
      PH_IAC: begin
        if (in_byte == B_IAC) begin
          burst.kind = BURST_DATA;
        end else if (in_byte >= B_SB) begin
          held_command_next = in_byte;
          phase_next        = PH_CMD;
        end
      end
      PH_CMD: begin
        if (held_command == B_SB) begin
          if (in_byte == B_SE) begin
            burst.kind = BURST_TTYPE;
          end else begin
            phase_next = PH_SUB;
          end
        end else begin
          burst.kind = BURST_REPLY;
          if (held_command == B_DO && (in_byte == OPT_SGA || in_byte == OPT_TTYPE)) begin
            burst.cmd = B_WILL;
          end else if (held_command == B_WILL || held_command == B_WONT) begin
            if (in_byte == OPT_ECHO || in_byte == OPT_SGA || in_byte == OPT_TTYPE) begin
              burst.cmd = B_DO;
            end else begin
              burst.cmd = B_DONT;
            end
          end
        end
      end
      PH_SUB: begin
        if (in_byte == B_SE) begin
          burst.kind = BURST_TTYPE;
        end else begin
          phase_next = PH_SUB;
        end
      end
      default: begin
        if (in_byte == B_IAC) begin
          phase_next = PH_IAC;
        end else begin
          burst.kind = BURST_DATA;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NORMAL;
      held_command <= 8'd0;
    end else if (accept) begin
      phase        <= phase_next;
      held_command <= held_command_next;
    end
  end

endmodule

@@ rtl/core/tor_emitter.sv @@
// result register: holds one burst and steps through its bytes, one result per cycle while out_ready is high
// depends on tor_pkg
module tor_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  tor_pkg::burst_t burst,
  output logic            free,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            to_server,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import tor_pkg::*;

  logic             busy;
  burst_kind_t      kind;
  logic [7:0]       cmd;
  logic [7:0]       opt;
  logic [IDX_W-1:0] idx;
  logic             take;

  always_comb begin
    last_of_run = 1'b1;
    out_byte    = opt;
    unique case (kind)
      BURST_REPLY: begin
        last_of_run = (idx == IDX_W'(REPLY_LEN - 1));
        if (idx == IDX_W'(0)) begin
          out_byte = B_IAC;
        end else if (idx == IDX_W'(1)) begin
          out_byte = cmd;
        end
      end
      BURST_TTYPE: begin
        last_of_run = (idx == IDX_W'(TTYPE_LEN - 1));
        out_byte    = ttype_byte(idx);
      end
      default: begin
        last_of_run = 1'b1;
        out_byte    = opt;
      end
    endcase
  end

  assign to_server = (kind != BURST_DATA);
  assign out_valid = busy;
  assign take      = busy && out_ready;
  assign free      = !busy || (take && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      kind <= BURST_NONE;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      kind <= burst.kind;
      idx  <= '0;
    end else if (take) begin
      if (last_of_run) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= burst.cmd;
      opt <= burst.opt;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free) else $error("burst loaded over a pending one");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((kind == BURST_DATA && idx == IDX_W'(0)) ||
              (kind == BURST_REPLY && idx < IDX_W'(REPLY_LEN)) ||
              (kind == BURST_TTYPE && idx < IDX_W'(TTYPE_LEN))))
    else $error("burst index out of range");

  a_step: assert property (@(posedge clk) disable iff (rst)
    take && !last_of_run |=> busy && idx == $past(idx) + IDX_W'(1))
    else $error("burst did not advance");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && last_of_run && !load |=> !busy)
    else $error("burst not released after last result");
`endif

endmodule

@@ bench/tb.sv @@
// testbench for telnet_option_responder: directed table then random byte stream, results
// checked against an in-bench predictor of the option parser, typed table rows against
// their own value; depends on tor_pkg and the telnet_option_responder rtl
`timescale 1ns / 100ps

module tb;
  import tor_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 144;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [79:0] TTYPE_ANSWER = 80'hFF_FA_18_00_41_4E_53_49_FF_F0;

  typedef struct packed {
    logic       srv;
    logic [7:0] val;
    logic       last;
  } reply_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [7:0] val;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       to_server;
  logic [7:0] out_byte;
  logic       last_of_run;

  logic       row_typed = 1'b0;
  logic [7:0] row_val = 8'd0;
  logic       quiet = 1'b0;
  int         mismatches = 0;
  int         cycle_cnt = 0;

  phase_t     rx_phase = PH_NORMAL;
  logic [7:0] rx_cmd = 8'd0;
  reply_t     fresh_q[$];
  reply_t     expected_q[$];
  dir_row_t   dir_tab [26];

  telnet_option_responder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .to_server  (to_server),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  function automatic reply_t reply_of(input logic srv, input logic [7:0] val, input logic last);
    reply_t r;
    r.srv = srv;
    r.val = val;
    r.last = last;
    return r;
  endfunction

  function automatic void queue_answer(input logic [7:0] cmd, input logic [7:0] opt);
    fresh_q.push_back(reply_of(1'b1, B_IAC, 1'b0));
    fresh_q.push_back(reply_of(1'b1, cmd, 1'b0));
    fresh_q.push_back(reply_of(1'b1, opt, 1'b1));
  endfunction

  function automatic void queue_ttype();
    for (int k = 0; k < 10; k++) begin
      fresh_q.push_back(reply_of(1'b1, TTYPE_ANSWER[79-8*k -: 8], k == 9));
    end
  endfunction

  function automatic void predict_replies(input logic [7:0] b);
    case (rx_phase)
      PH_IAC: begin
        if (b == B_IAC) begin
          rx_phase = PH_NORMAL;
          fresh_q.push_back(reply_of(1'b0, B_IAC, 1'b1));
        end else if (b >= B_SB) begin
          rx_cmd = b;
          rx_phase = PH_CMD;
        end else begin
          rx_phase = PH_NORMAL;
        end
      end
      PH_CMD: begin
        if (rx_cmd == B_SB) begin
          if (b == B_SE) begin
            rx_phase = PH_NORMAL;
            queue_ttype();
          end else begin
            rx_phase = PH_SUB;
          end
        end else begin
          rx_phase = PH_NORMAL;
          if (rx_cmd == B_DO && (b == OPT_SGA || b == OPT_TTYPE)) begin
            queue_answer(B_WILL, b);
          end else if (rx_cmd == B_WILL || rx_cmd == B_WONT) begin
            if (b == OPT_ECHO || b == OPT_SGA || b == OPT_TTYPE) queue_answer(B_DO, b);
            else queue_answer(B_DONT, b);
          end else begin
            queue_answer(B_WONT, b);
          end
        end
      end
      PH_SUB: begin
        if (b == B_SE) begin
          rx_phase = PH_NORMAL;
          queue_ttype();
        end
      end
      default: begin
        if (b == B_IAC) begin
          rx_phase = PH_IAC;
        end else begin
          rx_phase = PH_NORMAL;
          fresh_q.push_back(reply_of(1'b0, b, 1'b1));
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_option();
    logic [7:0] opts [6];
    opts = '{OPT_ECHO, OPT_SGA, OPT_TTYPE, 8'd0, 8'd255, B_SE};
    if ($urandom_range(1) == 0) return opts[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  task automatic flag_mismatch(input string what, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected srv=%0d byte=%02h last=%0d, got srv=%0d byte=%02h last=%0d",
               what, want.srv, want.val, want.last, got.srv, got.val, got.last);
    end
  endtask

  task automatic send_request(input logic [7:0] b, input logic typed, input logic [7:0] val);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    row_typed <= typed;
    row_val <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver side back-pressure
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    if (rst) begin
      rx_phase = PH_NORMAL;
      rx_cmd = 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        fresh_q.delete();
        predict_replies(in_byte);
        if (row_typed) expected_q.push_back(reply_of(1'b0, row_val, 1'b1));
        else foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
      end
      if (out_valid && out_ready) begin
        got = reply_of(to_server, out_byte, last_of_run);
        if (expected_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.srv !== want.srv || got.val !== want.val || got.last !== want.last)
            flag_mismatch("mismatch", want, got);
        end
      end
    end
  end

  initial begin
    int sent;
    int kind;
    int n;
    logic [7:0] x;

    dir_tab = '{
      '{8'h00, 1'b1, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{B_IAC, 1'b1, 8'hFF},
      '{B_IAC, 1'b0, 8'h00}, '{B_DO, 1'b0, 8'h00}, '{OPT_SGA, 1'b0, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{B_WILL, 1'b0, 8'h00}, '{OPT_TTYPE, 1'b0, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{B_WONT, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{B_DONT, 1'b0, 8'h00}, '{OPT_ECHO, 1'b0, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{8'hF1, 1'b0, 8'h00},
      '{8'hFE, 1'b1, 8'hFE},
      '{B_IAC, 1'b0, 8'h00}, '{B_SB, 1'b0, 8'h00}, '{B_SE, 1'b0, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{B_SB, 1'b0, 8'h00}, '{OPT_TTYPE, 1'b0, 8'h00},
      '{B_IAC, 1'b0, 8'h00}, '{B_SE, 1'b0, 8'h00}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_request(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].val);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet <= (sent >= 60 && sent < 110);
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_request(8'($urandom_range(254)), 1'b0, 8'h00);
        sent += 1;
      end else if (kind < 38) begin
        send_request(B_IAC, 1'b0, 8'h00);
        send_request(B_IAC, 1'b0, 8'h00);
        sent += 2;
      end else if (kind < 70) begin
        send_request(B_IAC, 1'b0, 8'h00);
        send_request(8'(B_WILL + $urandom_range(3)), 1'b0, 8'h00);
        send_request(pick_option(), 1'b0, 8'h00);
        sent += 3;
      end else if (kind < 82) begin
        // subnegotiation with a short random body
        send_request(B_IAC, 1'b0, 8'h00);
        send_request(B_SB, 1'b0, 8'h00);
        n = $urandom_range(4);
        for (int k = 0; k < n; k++) begin
          x = (k == 0) ? pick_option() : 8'($urandom_range(255));
          if (x == B_SE) x = 8'hF1;
          send_request(x, 1'b0, 8'h00);
        end
        send_request(B_SE, 1'b0, 8'h00);
        sent += n + 3;
      end else if (kind < 90) begin
        send_request(B_IAC, 1'b0, 8'h00);
        send_request(8'($urandom_range(249)), 1'b0, 8'h00);
        sent += 2;
      end else begin
        send_request(8'($urandom_range(255)), 1'b0, 8'h00);
        sent += 1;
      end
    end
    in_valid <= 1'b0;
    quiet <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tor_pkg.sv
rtl/core/tor_parser.sv
rtl/core/tor_emitter.sv
rtl/core/telnet_option_responder.sv
bench/tb.sv
